[rtl/assert_macros.svh]
// Assertion macros for the RTL of the CAL block.
// Expects clk and arst_n in scope; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CAL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define CAL_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define CAL_ASSERT(lbl, prop, msg)
`define CAL_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[rtl/cal_pkg.sv]
// Package of the CAN alias allocation and frame filter: widths, codes,
// command record passed from front to back, frame builder functions. No dependencies.
`timescale 1ns / 1ps

package cal_pkg;

	localparam int NodeIdW  = 48;
	localparam int WaitW    = 16;
	localparam int IdW      = 29;
	localparam int DataW    = 64;
	localparam int LenW     = 4;
	localparam int AliasW   = 12;
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 48;

	// command queue between front and back
	localparam int QDepth = 2;
	localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int QCntW  = $clog2(QDepth + 1);

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] RegNodeId    = 1'd0;
	localparam logic [CfgIdxW-1:0] RegWaitTicks = 1'd1;

	localparam logic [WaitW-1:0] WaitReset = 16'd250;

	// identifier bits 28..12 of control frames
	localparam logic [16:0] HdrRid = 17'h10700;
	localparam logic [16:0] HdrAmd = 17'h10701;
	localparam logic [16:0] HdrAme = 17'h10702;
	localparam logic [16:0] HdrAmr = 17'h10703;

	// identifier bits 28..24 of check-ID frames
	localparam logic [4:0] TopCid1 = 5'h17;
	localparam logic [4:0] TopCid2 = 5'h16;
	localparam logic [4:0] TopCid3 = 5'h15;
	localparam logic [4:0] TopCid4 = 5'h14;

	localparam logic [AliasW-1:0] AliasZero = 12'h000;
	localparam logic [AliasW-1:0] AliasMin  = 12'h001;
	localparam logic [AliasW-1:0] AliasAll  = 12'hFFF;
	localparam logic [AliasW-1:0] AliasMax  = 12'hFFE;

	localparam logic [LenW-1:0] LenMax    = 4'd8;
	localparam logic [LenW-1:0] LenNodeId = 4'd6;

	typedef enum logic [1:0] {
		ActStart,
		ActRecv,
		ActTick,
		ActSend
	} action_t;

	typedef enum logic [1:0] {
		PhIdle,
		PhCheck,
		PhRetry,
		PhPerm
	} phase_t;

	typedef enum logic [1:0] {
		KindTx,
		KindDeliver,
		KindComplete,
		KindRefused
	} kind_t;

	typedef enum logic [2:0] {
		CmdStart,     // four check-ID frames
		CmdRid,       // reserve-ID
		CmdAmrStart,  // map reset, then four check-ID frames
		CmdAmd,       // map definition
		CmdDeliver,   // message upward
		CmdComplete,  // reserve, map definition, init complete
		CmdSend,      // user frame
		CmdRefuse     // send refused
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t            op;
		logic [AliasW-1:0]  alias_a;  // alias held when the item came in
		logic [AliasW-1:0]  alias_b;  // alias of a new check
		logic [IdW-1:0]     id;
		logic [DataW-1:0]   data;
		logic [LenW-1:0]    len;
	} cmd_t;

	typedef struct packed {
		logic               full;
		logic               empty;
		logic [QCntW-1:0]   count;
	} q_stat_t;

	// top len bytes set, len clamped to eight
	function automatic logic [DataW-1:0] byte_mask(input logic [LenW-1:0] len);
		logic [LenW-1:0] l;
		l = (len > LenMax) ? LenMax : len;
		byte_mask = ~({DataW{1'b1}} >> {l, 3'b000});
	endfunction

	// index of the final result of a command
	function automatic logic [2:0] last_idx(input cmd_op_t op);
		case (op)
			CmdStart:    last_idx = 3'd3;
			CmdAmrStart: last_idx = 3'd4;
			CmdComplete: last_idx = 3'd2;
			default:     last_idx = 3'd0;
		endcase
	endfunction

	// check-ID frame k carries one 12-bit slice of the node ID
	function automatic logic [IdW-1:0] cid_id(input logic [1:0] k,
			input logic [NodeIdW-1:0] u, input logic [AliasW-1:0] a);
		case (k)
			2'd0:    cid_id = {TopCid1, u[47:36], a};
			2'd1:    cid_id = {TopCid2, u[35:24], a};
			2'd2:    cid_id = {TopCid3, u[23:12], a};
			default: cid_id = {TopCid4, u[11:0], a};
		endcase
	endfunction

endpackage

[rtl/cal_if.sv]
// Valid/ready channel interfaces for input items and result items.
// Depends on cal_pkg for field widths.
`timescale 1ns / 1ps

interface cal_in_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  action;
	logic [cal_pkg::IdW-1:0]     can_id;
	logic [cal_pkg::DataW-1:0]   payload;
	logic [cal_pkg::LenW-1:0]    length;
	logic [cal_pkg::AliasW-1:0]  candidate_alias;

	modport source (output valid, action, can_id, payload, length, candidate_alias,
		input ready);
	modport sink (input valid, action, can_id, payload, length, candidate_alias,
		output ready);
endinterface

interface cal_out_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  kind;
	logic [cal_pkg::IdW-1:0]     frame_id;
	logic [cal_pkg::DataW-1:0]   frame_data;
	logic [cal_pkg::LenW-1:0]    frame_length;
	logic [2:0]                  frame_type;
	logic [11:0]                 mti_or_dest;
	logic [cal_pkg::AliasW-1:0]  source_alias;
	logic                        last;

	modport source (output valid, kind, frame_id, frame_data, frame_length, frame_type,
		mti_or_dest, source_alias, last, input ready);
	modport sink (input valid, kind, frame_id, frame_data, frame_length, frame_type,
		mti_or_dest, source_alias, last, output ready);
endinterface

[rtl/can_alias_allocation_and_frame_filter_unit.sv]
// An accepted item's command is written into the command queue, then its results go through the output register.
// Throughput: one result per cycle from the back-end sequencer while res_ch.ready does not stall the output;
// an item with no result pushes no command.
// Input ready drops only when the two-entry command queue is full.
// Reset (arst_n low) clears alias state, queue and output valid; wait_ticks goes to 250.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module can_alias_allocation_and_frame_filter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	cal_in_if.sink                        req_ch,
	cal_out_if.source                     res_ch,
	input  logic                          cfg_we,
	input  logic [cal_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [cal_pkg::CfgDataW-1:0]  cfg_wdata
);
	import cal_pkg::*;

	q_stat_t              q_stat;
	logic                 push, pop;
	cmd_t                 push_cmd, head_cmd;
	logic [NodeIdW-1:0]   node_id;

	// classification and alias state
	cal_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_ch    (req_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_stat    (q_stat),
		.push      (push),
		.push_cmd  (push_cmd),
		.node_id   (node_id)
	);

	// command queue
	cal_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.q_stat   (q_stat)
	);

	// result sequencer
	cal_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_cmd   (head_cmd),
		.head_valid (!q_stat.empty),
		.node_id    (node_id),
		.pop        (pop),
		.res_ch     (res_ch)
	);

	// queue never overfills
	`CAL_ASSERT(a_q_bound, q_stat.count <= QCntW'(QDepth), "command queue overflow")
	// a start always leaves work queued behind it
	`CAL_ASSERT_NEXT(a_start_queued, req_ch.valid && req_ch.ready && (req_ch.action == ActStart) && q_stat.empty, !q_stat.empty, "start item produced no command")
	// completion and refusal results end their runs
	`CAL_ASSERT(a_single_last, !(res_ch.valid && (res_ch.kind == KindComplete || res_ch.kind == KindRefused)) || res_ch.last, "status result not marked last")
	// transmitted frames never exceed eight bytes
	`CAL_ASSERT(a_tx_len, !(res_ch.valid && res_ch.kind == KindTx) || (res_ch.frame_length <= LenMax), "transmit length above eight")

endmodule

[rtl/cal_front.sv]
// Front end: configuration registers, alias state machine, item classification.
// Depends on cal_pkg and cal_if; pushes one command per result-producing item.
`timescale 1ns / 1ps

module cal_front (
	input  logic                          clk,
	input  logic                          arst_n,
	cal_in_if.sink                        req_ch,
	input  logic                          cfg_we,
	input  logic [cal_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [cal_pkg::CfgDataW-1:0]  cfg_wdata,
	input  cal_pkg::q_stat_t              q_stat,
	output logic                          push,
	output cal_pkg::cmd_t                 push_cmd,
	output logic [cal_pkg::NodeIdW-1:0]   node_id
);
	import cal_pkg::*;

	logic [NodeIdW-1:0] node_id_q;
	logic [WaitW-1:0]   wait_ticks_q;
	phase_t             phase_q, phase_d;
	logic [AliasW-1:0]  own_alias_q, own_alias_d;
	logic               coll_q, coll_d;
	logic [WaitW-1:0]   countdown_q, countdown_d;

	logic               accept;
	action_t            act;
	logic [AliasW-1:0]  cand;
	logic [4:0]         top;
	logic [16:0]        mid;
	logic               alias_hit, is_cid, expired, enq_match, may_send;
	logic [LenW-1:0]    rlen;

	assign req_ch.ready = !q_stat.full;
	assign accept       = req_ch.valid && req_ch.ready;
	assign node_id      = node_id_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q    <= '0;
			wait_ticks_q <= WaitReset;
		end else if (cfg_we) begin
			case (cfg_index)
				RegNodeId:    node_id_q    <= cfg_wdata[NodeIdW-1:0];
				RegWaitTicks: wait_ticks_q <= cfg_wdata[WaitW-1:0];
				default:      ;
			endcase
		end
	end

	// shared decode of the incoming item
	always_comb begin
		act  = action_t'(req_ch.action);
		top  = req_ch.can_id[28:24];
		mid  = req_ch.can_id[28:12];
		rlen = (req_ch.length > LenMax) ? LenMax : req_ch.length;
		if (req_ch.candidate_alias == AliasZero)
			cand = AliasMin;
		else if (req_ch.candidate_alias == AliasAll)
			cand = AliasMax;
		else
			cand = req_ch.candidate_alias;
		alias_hit = (req_ch.can_id[11:0] == own_alias_q);
		is_cid    = top inside {[TopCid4:TopCid1]};
		expired   = (countdown_q <= 16'd1);
		enq_match = (req_ch.length == '0) ||
			((req_ch.length == LenNodeId) && (req_ch.payload[63:16] == node_id_q));
		may_send  = (req_ch.length <= LenMax) &&
			((phase_q == PhPerm) || is_cid || (mid == HdrRid) || (mid == HdrAmd));
	end

	// next state
	always_comb begin
		phase_d     = phase_q;
		own_alias_d = own_alias_q;
		coll_d      = coll_q;
		countdown_d = countdown_q;
		case (act)
			ActStart: begin
				phase_d     = PhCheck;
				own_alias_d = cand;
				coll_d      = 1'b0;
				countdown_d = wait_ticks_q;
			end
			ActRecv: begin
				if (phase_q != PhIdle && alias_hit && !is_cid) begin
					if (phase_q == PhPerm) begin
						phase_d     = PhCheck;
						own_alias_d = cand;
						coll_d      = 1'b0;
						countdown_d = wait_ticks_q;
					end else begin
						coll_d = 1'b1;
					end
				end
			end
			ActTick: begin
				if (phase_q == PhCheck || phase_q == PhRetry) begin
					if (!expired) begin
						countdown_d = countdown_q - 16'd1;
					end else if (phase_q == PhRetry) begin
						phase_d     = PhCheck;
						own_alias_d = cand;
						coll_d      = 1'b0;
						countdown_d = wait_ticks_q;
					end else if (coll_q) begin
						phase_d     = PhRetry;
						countdown_d = wait_ticks_q;
					end else begin
						phase_d     = PhPerm;
						countdown_d = '0;
					end
				end
			end
			default: ;
		endcase
	end

	// command toward the back end
	always_comb begin
		logic want;
		want             = 1'b0;
		push_cmd.op      = CmdRefuse;
		push_cmd.alias_a = own_alias_q;
		push_cmd.alias_b = cand;
		push_cmd.id      = req_ch.can_id;
		push_cmd.data    = req_ch.payload;
		push_cmd.len     = req_ch.length;
		case (act)
			ActStart: begin
				want        = 1'b1;
				push_cmd.op = CmdStart;
			end
			ActRecv: begin
				if (phase_q == PhIdle) begin
					want = 1'b0;
				end else if (alias_hit) begin
					if (is_cid) begin
						want        = 1'b1;
						push_cmd.op = CmdRid;
					end else if (phase_q == PhPerm) begin
						want        = 1'b1;
						push_cmd.op = CmdAmrStart;
					end
				end else if (phase_q == PhPerm) begin
					if (mid == HdrAme) begin
						want        = enq_match;
						push_cmd.op = CmdAmd;
					end else if (req_ch.can_id[28:27] == 2'b11) begin
						want         = 1'b1;
						push_cmd.op  = CmdDeliver;
						push_cmd.len = rlen;
					end
				end
			end
			ActTick: begin
				want        = (phase_q == PhCheck || phase_q == PhRetry) && expired &&
					!(phase_q == PhCheck && coll_q);
				push_cmd.op = (phase_q == PhRetry) ? CmdStart : CmdComplete;
			end
			default: begin
				want        = 1'b1;
				push_cmd.op = may_send ? CmdSend : CmdRefuse;
			end
		endcase
		push = accept && want;
	end

	// alias state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PhIdle;
			own_alias_q <= '0;
			coll_q      <= 1'b0;
			countdown_q <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			own_alias_q <= own_alias_d;
			coll_q      <= coll_d;
			countdown_q <= countdown_d;
		end
	end

endmodule

[rtl/cal_queue.sv]
// Short command queue that decouples the front end from the result sequencer.
// Depends on cal_pkg for the command record and depth.
`timescale 1ns / 1ps

module cal_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cal_pkg::cmd_t     push_cmd,
	input  logic              pop,
	output cal_pkg::cmd_t     head_cmd,
	output cal_pkg::q_stat_t  q_stat
);
	import cal_pkg::*;

	localparam logic [QPtrW-1:0] PtrLast = QPtrW'(QDepth - 1);

	cmd_t              mem_q [QDepth];
	logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0]  count_q;

	assign head_cmd     = mem_q[rd_ptr_q];
	assign q_stat.count = count_q;
	assign q_stat.full  = (count_q == QCntW'(QDepth));
	assign q_stat.empty = (count_q == '0);

	// storage, written at the tail
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

[rtl/cal_back.sv]
// Back end: expands each queued command into its run of result items.
// Depends on cal_pkg and cal_if; one result per cycle into the output register while the output is not stalled.
`timescale 1ns / 1ps

module cal_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cal_pkg::cmd_t                head_cmd,
	input  logic                         head_valid,
	input  logic [cal_pkg::NodeIdW-1:0]  node_id,
	output logic                         pop,
	cal_out_if.source                    res_ch
);
	import cal_pkg::*;

	logic [2:0]        idx_q;
	logic              out_valid_q;
	kind_t             kind_q, r_kind;
	logic [IdW-1:0]    id_q, r_id;
	logic [DataW-1:0]  data_q, r_data;
	logic [LenW-1:0]   len_q, r_len;
	logic [2:0]        ft_q, r_ft;
	logic [11:0]       md_q, r_md;
	logic [AliasW-1:0] sa_q, r_sa;
	logic              last_q, r_last;
	logic              load;
	logic [2:0]        idx_m1;
	logic [DataW-1:0]  id_bytes;

	assign load     = head_valid && (!out_valid_q || res_ch.ready);
	assign r_last   = (idx_q == last_idx(head_cmd.op));
	assign pop      = load && r_last;
	assign idx_m1   = idx_q - 3'd1;
	assign id_bytes = {node_id, 16'h0000};

	// build the result at the current run index
	always_comb begin
		r_kind = KindTx;
		r_id   = '0;
		r_data = '0;
		r_len  = '0;
		r_ft   = '0;
		r_md   = '0;
		r_sa   = '0;
		case (head_cmd.op)
			CmdStart: begin
				r_id = cid_id(idx_q[1:0], node_id, head_cmd.alias_b);
			end
			CmdAmrStart: begin
				if (idx_q == 3'd0) begin
					r_id   = {HdrAmr, head_cmd.alias_a};
					r_data = id_bytes;
					r_len  = LenNodeId;
				end else begin
					r_id = cid_id(idx_m1[1:0], node_id, head_cmd.alias_b);
				end
			end
			CmdRid: begin
				r_id = {HdrRid, head_cmd.alias_a};
			end
			CmdAmd: begin
				r_id   = {HdrAmd, head_cmd.alias_a};
				r_data = id_bytes;
				r_len  = LenNodeId;
			end
			CmdComplete: begin
				if (idx_q == 3'd0) begin
					r_id = {HdrRid, head_cmd.alias_a};
				end else if (idx_q == 3'd1) begin
					r_id   = {HdrAmd, head_cmd.alias_a};
					r_data = id_bytes;
					r_len  = LenNodeId;
				end else begin
					r_kind = KindComplete;
				end
			end
			CmdSend: begin
				r_id   = {head_cmd.id[28:12], head_cmd.alias_a};
				r_data = head_cmd.data & byte_mask(head_cmd.len);
				r_len  = head_cmd.len;
			end
			CmdDeliver: begin
				r_kind = KindDeliver;
				r_id   = head_cmd.id;
				r_data = head_cmd.data & byte_mask(head_cmd.len);
				r_len  = head_cmd.len;
				r_ft   = head_cmd.id[26:24];
				r_md   = head_cmd.id[23:12];
				r_sa   = head_cmd.id[11:0];
			end
			default: begin
				r_kind = KindRefused;
			end
		endcase
	end

	// run index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= r_last ? 3'd0 : idx_q + 3'd1;
			if (load)
				out_valid_q <= 1'b1;
			else if (res_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= r_kind;
			id_q   <= r_id;
			data_q <= r_data;
			len_q  <= r_len;
			ft_q   <= r_ft;
			md_q   <= r_md;
			sa_q   <= r_sa;
			last_q <= r_last;
		end
	end

	assign res_ch.valid        = out_valid_q;
	assign res_ch.kind         = kind_q;
	assign res_ch.frame_id     = id_q;
	assign res_ch.frame_data   = data_q;
	assign res_ch.frame_length = len_q;
	assign res_ch.frame_type   = ft_q;
	assign res_ch.mti_or_dest  = md_q;
	assign res_ch.source_alias = sa_q;
	assign res_ch.last         = last_q;

endmodule
